FILE: rtl/core/sli_pkg.sv
// shared types and constants for the sequence list insert/delete unit
// no dependencies; imported by the top level of the block and by the testbench
`default_nettype none

package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int INDEX_W = 6;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_APPEND    = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SHIFT,
        ST_EMIT_START,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
        logic        [POS_W-1:0]    position;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  entry_value;
        logic        [INDEX_W-1:0]  entry_index;
        logic                       last;
        logic                       empty_res;
        logic                       overflow;
    } t_out;

endpackage

`default_nettype wire

FILE: rtl/core/sli_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sli_addr.sv
// shared address unit: logical offset from the ring head to a physical ram address
// no dependencies
`default_nettype none

module sli_addr #(
    parameter int DEPTH = 64
) (
    input  wire logic [$clog2(DEPTH)-1:0] i_base,
    input  wire logic [$clog2(DEPTH)-1:0] i_offset,
    output logic      [$clog2(DEPTH)-1:0] o_phys
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] sum;

    // both operands are below depth, so one conditional subtract wraps the ring
    always_comb begin
        sum = (AW+1)'(i_base) + (AW+1)'(i_offset);
        if (sum >= (AW+1)'(DEPTH)) begin
            o_phys = AW'(sum - (AW+1)'(DEPTH));
        end else begin
            o_phys = AW'(sum);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sequence_list_insert_delete_unit.sv
// top level of the bounded sequence list: sequencer, ring pointers and output register
// depends on sli_pkg, sli_ram and sli_addr
`default_nettype none

// Bounded ordered list of up to DEPTH signed 32-bit values, kept in a ring
// buffer in a single ram with a head pointer and an entry count. A command
// inserts at the front (head moves back one slot), appends at the back,
// deletes by position (entries behind the hole move forward one slot at a
// time through the ram) or changes nothing. After every command the whole
// list is sent out front to back, one output transaction per entry, the
// final one flagged last; an empty list sends one transaction flagged
// empty_res. An insert into a full list is dropped and every transaction of
// that command carries overflow. The block takes one command at a time and
// stalls its input until the last output transaction is loaded into the
// output register. The single read port of the ram sets the pace: one entry
// is read, moved or emitted per cycle, and emitting waits while the output
// register is stalled. The ram needs no clearing after reset since only
// slots below the count are read.
module sequence_list_insert_delete_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // command channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sli_pkg::t_in  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sli_pkg::t_out      o_out_data
);

    import sli_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer and command registers
    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_ovf, n_ovf;

    // ring pointers
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;

    // output register
    t_out                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    // ram and address unit hookup
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [VALUE_W-1:0]   rd_data;
    logic [AW-1:0]        au_offset;
    logic [AW-1:0]        au_phys;

    logic                 out_free;
    logic [AW-1:0]        head_dec;
    logic [AW-1:0]        rd_dec;

    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (au_phys),
        .o_rd_data (rd_data)
    );

    sli_addr #(
        .DEPTH (DEPTH)
    ) u_addr (
        .i_base   (r_head),
        .i_offset (au_offset),
        .o_phys   (au_phys)
    );

    // ring decrements: new front slot, and the slot one before the last read
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign rd_dec   = (r_rd_addr == '0) ? AW'(DEPTH - 1) : r_rd_addr - 1'b1;

    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_value   <= n_value;
        r_pos     <= n_pos;
        r_ovf     <= n_ovf;
        r_idx     <= n_idx;
        r_rd_addr <= n_rd_addr;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_addr   = r_rd_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = r_value;
        rd_en     = 1'b0;
        au_offset = '0;

        // downstream took the held transaction
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_value = i_in_data.value;
                    n_pos   = i_in_data.position;
                    n_ovf   = 1'b0;
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                n_state = ST_EMIT_START;
                case (r_cmd)
                    CMD_INS_FRONT, CMD_APPEND: begin
                        if (r_count == CW'(DEPTH)) begin
                            // full list, insert dropped
                            n_ovf = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_cmd == CMD_INS_FRONT) begin
                                wr_addr = head_dec;
                                n_head  = head_dec;
                            end else begin
                                au_offset = AW'(r_count);
                                wr_addr   = au_phys;
                            end
                        end
                    end
                    CMD_DELETE: begin
                        if (r_pos < POS_W'(r_count)) begin
                            if ((POS_W+1)'(r_pos) + 1'b1 < (POS_W+1)'(r_count)) begin
                                // fetch the entry behind the hole, move starts next cycle
                                au_offset = AW'(r_pos + 1'b1);
                                rd_en     = 1'b1;
                                n_rd_addr = au_phys;
                                n_idx     = AW'(r_pos);
                                n_state   = ST_SHIFT;
                            end else begin
                                // deleting the tail needs no move
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_SHIFT: begin
                // entry idx+1 is in the read register, write it one slot forward
                wr_en   = 1'b1;
                wr_addr = rd_dec;
                wr_data = rd_data;
                if ((CW+1)'(r_idx) + (CW+1)'(2) < (CW+1)'(r_count)) begin
                    au_offset = r_idx + AW'(2);
                    rd_en     = 1'b1;
                    n_rd_addr = au_phys;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = ST_EMIT_START;
                end
            end

            ST_EMIT_START: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_out.entry_value = '0;
                        n_out.entry_index = '0;
                        n_out.last        = 1'b1;
                        n_out.empty_res   = 1'b1;
                        n_out.overflow    = r_ovf;
                        n_out_valid       = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end else begin
                    // prefetch the front entry
                    au_offset = '0;
                    rd_en     = 1'b1;
                    n_idx     = '0;
                    n_state   = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    n_out.entry_value = rd_data;
                    n_out.entry_index = INDEX_W'(r_idx);
                    n_out.last        = (CW'(r_idx) == r_count - 1'b1);
                    n_out.empty_res   = 1'b0;
                    n_out.overflow    = r_ovf;
                    n_out_valid       = 1'b1;
                    if (CW'(r_idx) == r_count - 1'b1) begin
                        n_state = ST_IDLE;
                    end else begin
                        // read of the next entry overlaps the hand-off of this one
                        au_offset = r_idx + 1'b1;
                        rd_en     = 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: test/tb_sequence_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for sequence_list_insert_delete_unit: random and directed commands
// depends on sli_pkg and the rtl of the unit; predicts every emitted list entry itself

module tb_sequence_list_insert_delete_unit;
    import sli_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 110;
    localparam int MAX_IDLE       = 16;
    // receiver hold-off: after this many results, stall for a long stretch
    localparam int PRESSURE_AFTER = 300;
    localparam int LONG_HOLD      = 400;
    // no-acceptance cycles before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int REPORT_CAP     = 60;

    // clock, reset and the dut inputs driven here, all known from time zero
    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic drv_valid  = 1'b0;
    t_in  drv_data   = '0;
    logic mon_stall  = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    // a transaction moves on an edge where valid is high and stall is low
    wire in_fire  = drv_valid && !o_in_stall;
    wire out_fire = o_out_valid && !mon_stall;

    // stimulus waiting for the driver
    t_in command_queue[$];
    // list entries that the unit still owes us, oldest first
    t_out pending_entries[$];

    // shadow of the list, updated on every accepted command
    logic signed [VALUE_W-1:0] list_vals [LIST_DEPTH];
    int unsigned list_len = 0;

    // generator's own count, used to aim deletes and steer fill/drain phases
    int unsigned gen_len      = 0;
    int unsigned full_inserts = 0;

    int fail_count   = 0;
    int result_count = 0;
    int idle_cycles  = 0;

    // sender and receiver idling state
    int drv_gap       = 0;
    int mon_hold      = 0;
    bit drv_no_idle   = 1'b0;
    bit mon_no_idle   = 1'b0;

    sequence_list_insert_delete_unit #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (drv_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (drv_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (mon_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one command to the shadow list and queue up the full list dump it causes
    function automatic void apply_list_command(input t_in c);
        t_out        r;
        logic        dropped;
        int unsigned i;
        dropped = 1'b0;
        case (c.cmd)
            CMD_INS_FRONT, CMD_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    // full list: insert is dropped, list untouched
                    dropped = 1'b1;
                end else if (c.cmd == CMD_INS_FRONT) begin
                    for (i = list_len; i > 0; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[0] = c.value;
                    list_len++;
                end else begin
                    list_vals[list_len] = c.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                // out-of-range position (or empty list) is ignored
                if (c.position < list_len) begin
                    for (i = c.position; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
            end
            default: begin
            end
        endcase
        if (list_len == 0) begin
            // empty list: one transaction, zero fields, last and empty_res set
            r           = '0;
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            r.overflow  = dropped;
            pending_entries.push_back(r);
        end else begin
            for (i = 0; i < list_len; i++) begin
                r.entry_value = list_vals[i];
                r.entry_index = INDEX_W'(i);
                r.last        = (i + 1 == list_len);
                r.empty_res   = 1'b0;
                r.overflow    = dropped;
                pending_entries.push_back(r);
            end
        end
    endfunction

    // queue a command and track what the list length will be
    function automatic void queue_cmd(input t_cmd c, input logic signed [VALUE_W-1:0] v,
                                      input logic [POS_W-1:0] p);
        t_in item;
        if (c == CMD_INS_FRONT || c == CMD_APPEND) begin
            if (gen_len == LIST_DEPTH)
                full_inserts++;
            else
                gen_len++;
        end else if (c == CMD_DELETE && p < gen_len) begin
            gen_len--;
        end
        item.cmd      = c;
        item.value    = v;
        item.position = p;
        command_queue.push_back(item);
    endfunction

    // data values, leaning on the extremes now and then
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // cycles to wait before the next transaction on one side
    function automatic int idle_draw(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            if (fail_count < REPORT_CAP)
                $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // stimulus: directed corners first, then fill/drain phases with random content
    initial begin : stimulus_build
        int   k;
        int   roll;
        bit   filling;
        t_cmd c;
        logic [POS_W-1:0] p;

        // empty list: no-change and delete both give a single empty transaction
        queue_cmd(CMD_NOP,       pick_value(),  8'd0);
        queue_cmd(CMD_DELETE,    pick_value(),  8'd0);
        // extremes of the value field at both ends
        queue_cmd(CMD_INS_FRONT, 32'sh7fff_ffff, 8'hff);
        queue_cmd(CMD_APPEND,    32'sh8000_0000, 8'h00);
        queue_cmd(CMD_INS_FRONT, -32'sd1,        8'h55);
        queue_cmd(CMD_APPEND,    32'sd0,         8'haa);
        // out-of-range deletes: far beyond and exactly at the count
        queue_cmd(CMD_DELETE,    pick_value(),  8'hff);
        queue_cmd(CMD_DELETE,    pick_value(),  8'd4);
        // delete the tail, then the head
        queue_cmd(CMD_DELETE,    pick_value(),  8'd3);
        queue_cmd(CMD_DELETE,    pick_value(),  8'd0);
        queue_cmd(CMD_INS_FRONT, 32'sd1,        8'd0);
        queue_cmd(CMD_APPEND,    32'sh5555_5555, 8'd0);
        queue_cmd(CMD_APPEND,    32'shaaaa_aaaa, 8'd0);
        // delete from the middle
        queue_cmd(CMD_DELETE,    pick_value(),  8'd1);
        queue_cmd(CMD_NOP,       pick_value(),  8'd0);
        // drain back to empty from the head
        while (gen_len > 0)
            queue_cmd(CMD_DELETE, pick_value(), 8'd0);
        queue_cmd(CMD_DELETE,    pick_value(),  8'haa);

        // random part: fill until several inserts hit a full list, then drain to empty
        filling = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (filling) begin
                if (roll < 47)      c = CMD_INS_FRONT;
                else if (roll < 94) c = CMD_APPEND;
                else if (roll < 97) c = CMD_DELETE;
                else                c = CMD_NOP;
            end else begin
                if (roll < 85)      c = CMD_DELETE;
                else if (roll < 90) c = CMD_INS_FRONT;
                else if (roll < 95) c = CMD_APPEND;
                else                c = CMD_NOP;
            end
            // deletes mostly hit a live entry, sometimes any position at all
            if (c == CMD_DELETE && gen_len > 0 && $urandom_range(0, 7) != 0)
                p = POS_W'($urandom_range(0, gen_len - 1));
            else
                p = POS_W'($urandom_range(0, 255));
            queue_cmd(c, pick_value(), p);
            if (filling && full_inserts >= 4) begin
                filling = 1'b0;
            end else if (!filling && gen_len == 0) begin
                filling      = 1'b1;
                full_inserts = 0;
            end
        end
    end

    // reset, wait for everything to drain, then the verdict
    initial begin : run_control
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (command_queue.size() != 0 || drv_valid || pending_entries.size() != 0)
            @(negedge i_clk);
        // let any stray transaction show up before judging
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // command driver: holds each transaction until accepted, random gaps between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                // accepted: predict now, in acceptance order
                apply_list_command(drv_data);
                if ($urandom_range(0, 15) == 0)
                    drv_no_idle = !drv_no_idle;
                drv_gap = idle_draw(drv_no_idle);
            end
            // payload only changes when nothing is held
            if (in_fire || !drv_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    drv_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    drv_data  <= command_queue.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transaction against the oldest owed entry
    always @(posedge i_clk) begin : result_monitor
        t_out want;
        if (!i_rst_n) begin
            mon_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                if (pending_entries.size() == 0) begin
                    if (fail_count < REPORT_CAP)
                        $error("unexpected transaction: entry_value %0d entry_index %0d",
                               o_out_data.entry_value, o_out_data.entry_index);
                    fail_count++;
                end else begin
                    want = pending_entries.pop_front();
                    check_field("entry_value", want.entry_value, o_out_data.entry_value);
                    check_field("entry_index", want.entry_index, o_out_data.entry_index);
                    check_field("last",        want.last,        o_out_data.last);
                    check_field("empty_res",   want.empty_res,   o_out_data.empty_res);
                    check_field("overflow",    want.overflow,    o_out_data.overflow);
                end
                result_count++;
                if ($urandom_range(0, 15) == 0)
                    mon_no_idle = !mon_no_idle;
                // one long hold-off so the unit backs up into the command side
                if (result_count == PRESSURE_AFTER)
                    mon_hold = LONG_HOLD;
                else
                    mon_hold = idle_draw(mon_no_idle);
            end
            if (mon_hold > 0) begin
                mon_hold--;
                mon_stall <= 1'b1;
            end else begin
                mon_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any transaction on either side means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
rtl/core/sli_pkg.sv
rtl/core/sli_ram.sv
rtl/core/sli_addr.sv
rtl/core/sequence_list_insert_delete_unit.sv
test/tb_sequence_list_insert_delete_unit.sv
